// ----- sv/mcfr_pkg.sv -----
`default_nettype none

package mcfr_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int QW = DW + FB;
  localparam int KW = 18;
  localparam int EW = 16;

  typedef logic signed [DW-1:0]   word_t;
  typedef logic signed [2*DW-1:0] dword_t;

  localparam word_t  MAXV    = {1'b0, {(DW-1){1'b1}}};
  localparam word_t  MINV    = {1'b1, {(DW-1){1'b0}}};
  localparam word_t  ONE     = word_t'(1) <<< FB;
  localparam word_t  TWO     = word_t'(2) <<< FB;
  localparam word_t  QUARTER = word_t'(1) <<< (FB - 2);
  localparam dword_t RND     = (dword_t'(1) <<< FB) - dword_t'(1);

  localparam logic REG_KAPPA = 1'b0;
  localparam logic REG_EPS   = 1'b1;

  typedef struct packed {
    logic  f;
    word_t v;
  } sres_t;

  typedef struct packed {
    logic  v;
    logic  f;
    word_t d2;
    word_t d;
    word_t base;
  } corr_in_t;

  typedef struct packed {
    logic  v;
    logic  f;
    logic  p;
    word_t a;
    word_t b;
    word_t c;
  } side_t;

  typedef struct packed {
    logic  v;
    logic  f;
    word_t val;
  } face_t;

  function automatic sres_t sat33(input logic signed [DW:0] s);
    sres_t r;
    if (s[DW] != s[DW-1]) begin
      r.f = 1'b1;
      r.v = s[DW] ? MINV : MAXV;
    end else begin
      r.f = 1'b0;
      r.v = s[DW-1:0];
    end
    return r;
  endfunction

  function automatic sres_t add_sat(input word_t a, input word_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    return sat33(s);
  endfunction

  function automatic sres_t sub_sat(input word_t a, input word_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    return sat33(s);
  endfunction

  // Product scaled back by the fraction bits, truncated toward zero.
  function automatic sres_t mul_post(input dword_t p);
    dword_t          adj;
    logic [QW-1:0]   sh;
    logic [QW-DW:0]  hi;
    sres_t           r;
    adj = p + (p[2*DW-1] ? RND : dword_t'(0));
    sh  = adj[2*DW-1:FB];
    hi  = sh[QW-1:DW-1];
    if ((&hi) || !(|hi)) begin
      r.f = 1'b0;
      r.v = sh[DW-1:0];
    end else begin
      r.f = 1'b1;
      r.v = sh[QW-1] ? MINV : MAXV;
    end
    return r;
  endfunction

  function automatic dword_t mul(input word_t a, input word_t b);
    return dword_t'(a) * dword_t'(b);
  endfunction

endpackage

`default_nettype wire

// ----- sv/mcfr_if.sv -----
`default_nettype none

interface mcfr_in_if;
  logic            valid;
  logic            ready;
  mcfr_pkg::word_t value_left;
  mcfr_pkg::word_t value_right;
  mcfr_pkg::word_t grad_left_x;
  mcfr_pkg::word_t grad_left_y;
  mcfr_pkg::word_t grad_left_z;
  mcfr_pkg::word_t grad_right_x;
  mcfr_pkg::word_t grad_right_y;
  mcfr_pkg::word_t grad_right_z;
  mcfr_pkg::word_t offset_x;
  mcfr_pkg::word_t offset_y;
  mcfr_pkg::word_t offset_z;

  modport source (
    output valid, value_left, value_right, grad_left_x, grad_left_y, grad_left_z,
           grad_right_x, grad_right_y, grad_right_z, offset_x, offset_y, offset_z,
    input  ready
  );
  modport sink (
    input  valid, value_left, value_right, grad_left_x, grad_left_y, grad_left_z,
           grad_right_x, grad_right_y, grad_right_z, offset_x, offset_y, offset_z,
    output ready
  );
endinterface

interface mcfr_out_if;
  logic            valid;
  logic            ready;
  mcfr_pkg::word_t face_left;
  mcfr_pkg::word_t face_right;
  logic            saturated;

  modport source (output valid, face_left, face_right, saturated, input ready);
  modport sink (input valid, face_left, face_right, saturated, output ready);
endinterface

`default_nettype wire

// ----- sv/muscl_face_reconstruction_unit.sv -----
// MUSCL-kappa face reconstruction with the van Leer limiter in signed Q16.16.
// The block accepts one face per clock cycle unless the output stalls, and
// returns its two face states in order through two pipelined 48-step
// dividers in series per side (the slope ratio, then the limiter terms) and
// the dot-product and multiplier stages. An output stall freezes the whole
// pipeline, so no beat is lost or repeated. saturated flags any clamp inside
// the datapath. The user must write kappa and guard_epsilon through the
// configuration port while the block is idle; the block does not enforce it.
`default_nettype none

module muscl_face_reconstruction_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mcfr_in_if.sink                       in_i,
  mcfr_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [mcfr_pkg::KW-1:0]       cfg_data_i
);

  localparam int DW = mcfr_pkg::DW;

  logic signed [mcfr_pkg::KW-1:0] kappa_q;
  logic [mcfr_pkg::EW-1:0]        eps_q;
  mcfr_pkg::word_t                kap_w, eps_w, opk, omk;

  logic                en;
  mcfr_pkg::face_t     face_l, face_r;

  logic                v1_q, v2_q, v3_q, v4_q, v5_q;
  mcfr_pkg::word_t     vl1_q, vr1_q, vl2_q, vr2_q, vl3_q, vr3_q;
  mcfr_pkg::word_t     vl4_q, vr4_q, vl5_q, vr5_q;
  mcfr_pkg::sres_t     d2_d;
  mcfr_pkg::word_t     d21_q, d22_q, d23_q, d24_q, d25_q;
  logic                f1_q;
  mcfr_pkg::dword_t    pl_q [0:2];
  mcfr_pkg::dword_t    pr_q [0:2];
  mcfr_pkg::sres_t     ml_d [0:2];
  mcfr_pkg::sres_t     mr_d [0:2];
  mcfr_pkg::word_t     ml_q [0:2];
  mcfr_pkg::word_t     mr_q [0:2];
  logic                fl2_q, fr2_q;
  mcfr_pkg::sres_t     sl_d, sr_d, dl_d, dr_d, tl_d, tr_d, el_d, er_d;
  mcfr_pkg::word_t     sl3_q, sr3_q, zl3_q, zr3_q;
  logic                fl3_q, fr3_q;
  mcfr_pkg::word_t     dl4_q, dr4_q;
  logic                fl4_q, fr4_q;
  mcfr_pkg::word_t     tl5_q, tr5_q;
  logic                fl5_q, fr5_q;
  mcfr_pkg::corr_in_t  cl_q, cr_q;
  mcfr_pkg::corr_in_t  cl_d, cr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kappa_q <= mcfr_pkg::KW'(21845);
      eps_q   <= mcfr_pkg::EW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mcfr_pkg::REG_KAPPA: kappa_q <= cfg_data_i;
        mcfr_pkg::REG_EPS:   eps_q   <= cfg_data_i[mcfr_pkg::EW-1:0];
        default: ;
      endcase
    end
  end

  assign kap_w = DW'(kappa_q);
  assign eps_w = mcfr_pkg::word_t'({{(DW-mcfr_pkg::EW){1'b0}}, eps_q});
  assign opk   = mcfr_pkg::ONE + kap_w;
  assign omk   = mcfr_pkg::ONE - kap_w;

  assign en         = !face_l.v || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    d2_d = mcfr_pkg::sub_sat(in_i.value_right, in_i.value_left);
    for (int k = 0; k < 3; k++) begin
      ml_d[k] = mcfr_pkg::mul_post(pl_q[k]);
      mr_d[k] = mcfr_pkg::mul_post(pr_q[k]);
    end
    sl_d = mcfr_pkg::add_sat(ml_q[0], ml_q[1]);
    sr_d = mcfr_pkg::add_sat(mr_q[0], mr_q[1]);
    dl_d = mcfr_pkg::add_sat(sl3_q, zl3_q);
    dr_d = mcfr_pkg::add_sat(sr3_q, zr3_q);
    tl_d = mcfr_pkg::add_sat(dl4_q, dl4_q);
    tr_d = mcfr_pkg::add_sat(dr4_q, dr4_q);
    el_d = mcfr_pkg::sub_sat(tl5_q, d25_q);
    er_d = mcfr_pkg::sub_sat(tr5_q, d25_q);

    cl_d.v    = v5_q;
    cl_d.f    = fl5_q | el_d.f;
    cl_d.d2   = d25_q;
    cl_d.d    = el_d.v;
    cl_d.base = vl5_q;
    cr_d.v    = v5_q;
    cr_d.f    = fr5_q | er_d.f;
    cr_d.d2   = d25_q;
    cr_d.d    = er_d.v;
    cr_d.base = vr5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vl1_q   <= in_i.value_left;
      vr1_q   <= in_i.value_right;
      d21_q   <= d2_d.v;
      f1_q    <= d2_d.f;
      pl_q[0] <= mcfr_pkg::mul(in_i.grad_left_x, in_i.offset_x);
      pl_q[1] <= mcfr_pkg::mul(in_i.grad_left_y, in_i.offset_y);
      pl_q[2] <= mcfr_pkg::mul(in_i.grad_left_z, in_i.offset_z);
      pr_q[0] <= mcfr_pkg::mul(in_i.grad_right_x, in_i.offset_x);
      pr_q[1] <= mcfr_pkg::mul(in_i.grad_right_y, in_i.offset_y);
      pr_q[2] <= mcfr_pkg::mul(in_i.grad_right_z, in_i.offset_z);

      vl2_q <= vl1_q;
      vr2_q <= vr1_q;
      d22_q <= d21_q;
      for (int k = 0; k < 3; k++) begin
        ml_q[k] <= ml_d[k].v;
        mr_q[k] <= mr_d[k].v;
      end
      fl2_q <= f1_q | ml_d[0].f | ml_d[1].f | ml_d[2].f;
      fr2_q <= f1_q | mr_d[0].f | mr_d[1].f | mr_d[2].f;

      vl3_q <= vl2_q;
      vr3_q <= vr2_q;
      d23_q <= d22_q;
      sl3_q <= sl_d.v;
      sr3_q <= sr_d.v;
      zl3_q <= ml_q[2];
      zr3_q <= mr_q[2];
      fl3_q <= fl2_q | sl_d.f;
      fr3_q <= fr2_q | sr_d.f;

      vl4_q <= vl3_q;
      vr4_q <= vr3_q;
      d24_q <= d23_q;
      dl4_q <= dl_d.v;
      dr4_q <= dr_d.v;
      fl4_q <= fl3_q | dl_d.f;
      fr4_q <= fr3_q | dr_d.f;

      vl5_q <= vl4_q;
      vr5_q <= vr4_q;
      d25_q <= d24_q;
      tl5_q <= tl_d.v;
      tr5_q <= tr_d.v;
      fl5_q <= fl4_q | tl_d.f;
      fr5_q <= fr4_q | tr_d.f;

      cl_q  <= cl_d;
      cr_q  <= cr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  mcfr_corr u_corr_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .sub_i  (1'b0),
    .eps_i  (eps_w),
    .opk_i  (opk),
    .omk_i  (omk),
    .in_i   (cl_q),
    .out_o  (face_l)
  );

  mcfr_corr u_corr_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .sub_i  (1'b1),
    .eps_i  (eps_w),
    .opk_i  (opk),
    .omk_i  (omk),
    .in_i   (cr_q),
    .out_o  (face_r)
  );

  assign out_o.valid      = face_l.v;
  assign out_o.face_left  = face_l.val;
  assign out_o.face_right = face_r.val;
  assign out_o.saturated  = face_l.f | face_r.f;

endmodule

`default_nettype wire

// ----- sv/mcfr_div.sv -----
`default_nettype none

module mcfr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  mcfr_pkg::word_t   num_i,
  input  mcfr_pkg::word_t   den_i,
  input  mcfr_pkg::side_t   side_i,
  output mcfr_pkg::sres_t   quo_o,
  output mcfr_pkg::side_t   side_o
);

  localparam int DW = mcfr_pkg::DW;
  localparam int FB = mcfr_pkg::FB;
  localparam int N  = mcfr_pkg::QW;
  localparam logic [N-1:0] LIMP = N'(mcfr_pkg::MAXV);
  localparam logic [N-1:0] LIMN = LIMP + N'(1);

  typedef struct packed {
    logic zero;
    logic neg;
    logic npos;
    logic nneg;
  } meta_t;

  logic [DW-1:0]   rem_q  [0:N];
  logic [N-1:0]    dq_q   [0:N];
  logic [DW-1:0]   md_q   [0:N];
  meta_t           meta_q [0:N];
  mcfr_pkg::side_t side_q [0:N];

  logic [DW-1:0]   rem_n  [0:N-1];
  logic [N-1:0]    dq_n   [0:N-1];
  logic [DW:0]     t_n    [0:N-1];
  logic            ge_n   [0:N-1];

  logic [DW-1:0]   mn_d;
  logic [DW-1:0]   md_d;
  meta_t           meta_d;
  mcfr_pkg::sres_t res_d;
  mcfr_pkg::sres_t res_q;
  mcfr_pkg::side_t side_oq;
  logic [N-1:0]    quo;

  always_comb begin
    mn_d        = num_i[DW-1] ? (~num_i + DW'(1)) : num_i;
    md_d        = den_i[DW-1] ? (~den_i + DW'(1)) : den_i;
    meta_d.zero = (den_i == '0);
    meta_d.neg  = num_i[DW-1] ^ den_i[DW-1];
    meta_d.npos = !num_i[DW-1] && (num_i != '0);
    meta_d.nneg = num_i[DW-1];
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      t_n[i]   = {rem_q[i], dq_q[i][N-1]};
      ge_n[i]  = t_n[i] >= {1'b0, md_q[i]};
      rem_n[i] = ge_n[i] ? DW'(t_n[i] - {1'b0, md_q[i]}) : t_n[i][DW-1:0];
      dq_n[i]  = {dq_q[i][N-2:0], ge_n[i]};
    end
  end

  always_comb begin
    quo = dq_q[N];
    if (meta_q[N].zero) begin
      res_d.f = 1'b1;
      res_d.v = meta_q[N].npos ? mcfr_pkg::MAXV :
                (meta_q[N].nneg ? mcfr_pkg::MINV : '0);
    end else if (quo > (meta_q[N].neg ? LIMN : LIMP)) begin
      res_d.f = 1'b1;
      res_d.v = meta_q[N].neg ? mcfr_pkg::MINV : mcfr_pkg::MAXV;
    end else begin
      res_d.f = 1'b0;
      res_d.v = meta_q[N].neg ? -quo[DW-1:0] : quo[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      dq_q[0]   <= {mn_d, {FB{1'b0}}};
      md_q[0]   <= md_d;
      meta_q[0] <= meta_d;
      for (int i = 0; i < N; i++) begin
        rem_q[i+1]  <= rem_n[i];
        dq_q[i+1]   <= dq_n[i];
        md_q[i+1]   <= md_q[i];
        meta_q[i+1] <= meta_q[i];
      end
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= N; i++) begin
        side_q[i] <= '0;
      end
      side_oq <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 0; i < N; i++) begin
        side_q[i+1] <= side_q[i];
      end
      side_oq <= side_q[N];
    end
  end

  assign quo_o  = res_q;
  assign side_o = side_oq;

endmodule

`default_nettype wire

// ----- sv/mcfr_corr.sv -----
`default_nettype none

module mcfr_corr (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               sub_i,
  input  mcfr_pkg::word_t    eps_i,
  input  mcfr_pkg::word_t    opk_i,
  input  mcfr_pkg::word_t    omk_i,
  input  mcfr_pkg::corr_in_t in_i,
  output mcfr_pkg::face_t    out_o
);

  mcfr_pkg::sres_t  num_d, den_d;
  mcfr_pkg::word_t  num0_q, den0_q;
  mcfr_pkg::side_t  s0_d, s0_q;

  mcfr_pkg::sres_t  r_res;
  mcfr_pkg::side_t  s1_div;
  logic             pos;
  mcfr_pkg::sres_t  den2_d, two_d;
  mcfr_pkg::word_t  den1_q, two1_q;
  mcfr_pkg::side_t  s1_d, s1_q;

  mcfr_pkg::sres_t  phr_res, inv_res;
  mcfr_pkg::side_t  s2_div;
  mcfr_pkg::dword_t prod2_q;
  mcfr_pkg::word_t  phr2_q;
  mcfr_pkg::side_t  s2_d, s2_q;

  mcfr_pkg::sres_t  rpi_d;
  mcfr_pkg::word_t  rpi3_q, phr3_q;
  mcfr_pkg::side_t  s3_d, s3_q;

  mcfr_pkg::dword_t pa4_q, pb4_q;
  mcfr_pkg::side_t  s4_q;

  mcfr_pkg::sres_t  a5_d, b5_d;
  mcfr_pkg::word_t  a5_q, b5_q;
  mcfr_pkg::side_t  s5_d, s5_q;

  mcfr_pkg::sres_t  b6_d;
  mcfr_pkg::word_t  b6_q;
  mcfr_pkg::side_t  s6_d, s6_q;

  mcfr_pkg::dword_t prod7_q;
  mcfr_pkg::side_t  s7_q;

  mcfr_pkg::sres_t  q8_d;
  mcfr_pkg::word_t  q8_q;
  mcfr_pkg::side_t  s8_d, s8_q;

  mcfr_pkg::dword_t prod9_q;
  mcfr_pkg::side_t  s9_q;

  mcfr_pkg::sres_t  c10_d;
  mcfr_pkg::word_t  c10_q;
  mcfr_pkg::side_t  s10_d, s10_q;

  mcfr_pkg::sres_t  fin_d;
  mcfr_pkg::face_t  out_d, out_q;

  always_comb begin
    num_d   = mcfr_pkg::add_sat(in_i.d2, eps_i);
    den_d   = mcfr_pkg::add_sat(in_i.d, eps_i);
    s0_d.v  = in_i.v;
    s0_d.f  = in_i.f | num_d.f | den_d.f;
    s0_d.p  = 1'b0;
    s0_d.a  = in_i.d;
    s0_d.b  = '0;
    s0_d.c  = in_i.base;
  end

  mcfr_div u_div_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .num_i  (num0_q),
    .den_i  (den0_q),
    .side_i (s0_q),
    .quo_o  (r_res),
    .side_o (s1_div)
  );

  always_comb begin
    pos    = !r_res.v[mcfr_pkg::DW-1] && (r_res.v != '0);
    den2_d = mcfr_pkg::add_sat(mcfr_pkg::ONE, r_res.v);
    two_d  = mcfr_pkg::add_sat(r_res.v, r_res.v);
    s1_d   = s1_div;
    s1_d.f = s1_div.f | r_res.f | (pos & (den2_d.f | two_d.f));
    s1_d.p = pos;
    s1_d.b = r_res.v;
  end

  mcfr_div u_div_phi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .num_i  (two1_q),
    .den_i  (den1_q),
    .side_i (s1_q),
    .quo_o  (phr_res),
    .side_o (s2_div)
  );

  mcfr_div u_div_inv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .num_i  (mcfr_pkg::TWO),
    .den_i  (den1_q),
    .side_i (s1_q),
    .quo_o  (inv_res),
    .side_o ()
  );

  always_comb begin
    s2_d   = s2_div;
    s2_d.f = s2_div.f | (s2_div.p & (phr_res.f | inv_res.f));

    rpi_d  = mcfr_pkg::mul_post(prod2_q);
    s3_d   = s2_q;
    s3_d.f = s2_q.f | (s2_q.p & rpi_d.f);

    a5_d   = mcfr_pkg::mul_post(pa4_q);
    b5_d   = mcfr_pkg::mul_post(pb4_q);
    s5_d   = s4_q;
    s5_d.f = s4_q.f | a5_d.f | b5_d.f;

    b6_d   = mcfr_pkg::add_sat(a5_q, b5_q);
    s6_d   = s5_q;
    s6_d.f = s5_q.f | b6_d.f;

    q8_d   = mcfr_pkg::mul_post(prod7_q);
    s8_d   = s7_q;
    s8_d.f = s7_q.f | q8_d.f;

    c10_d   = mcfr_pkg::mul_post(prod9_q);
    s10_d   = s9_q;
    s10_d.f = s9_q.f | c10_d.f;

    fin_d     = sub_i ? mcfr_pkg::sub_sat(s10_q.c, c10_q)
                      : mcfr_pkg::add_sat(s10_q.c, c10_q);
    out_d.v   = s10_q.v;
    out_d.f   = s10_q.f | fin_d.f;
    out_d.val = fin_d.v;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num0_q  <= num_d.v;
      den0_q  <= den_d.v;
      den1_q  <= den2_d.v;
      two1_q  <= two_d.v;
      prod2_q <= mcfr_pkg::mul(s2_div.b, inv_res.v);
      phr2_q  <= phr_res.v;
      rpi3_q  <= s2_q.p ? rpi_d.v : '0;
      phr3_q  <= s2_q.p ? phr2_q : '0;
      pa4_q   <= mcfr_pkg::mul(opk_i, rpi3_q);
      pb4_q   <= mcfr_pkg::mul(omk_i, phr3_q);
      a5_q    <= a5_d.v;
      b5_q    <= b5_d.v;
      b6_q    <= b6_d.v;
      prod7_q <= mcfr_pkg::mul(mcfr_pkg::QUARTER, b6_q);
      q8_q    <= q8_d.v;
      prod9_q <= mcfr_pkg::mul(q8_q, s8_q.a);
      c10_q   <= c10_d.v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q  <= '0;
      s1_q  <= '0;
      s2_q  <= '0;
      s3_q  <= '0;
      s4_q  <= '0;
      s5_q  <= '0;
      s6_q  <= '0;
      s7_q  <= '0;
      s8_q  <= '0;
      s9_q  <= '0;
      s10_q <= '0;
      out_q <= '0;
    end else if (en_i) begin
      s0_q  <= s0_d;
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s3_q;
      s5_q  <= s5_d;
      s6_q  <= s6_d;
      s7_q  <= s6_q;
      s8_q  <= s8_d;
      s9_q  <= s8_q;
      s10_q <= s10_d;
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// ----- sv/mcfr_chk.sv -----
`default_nettype none

module mcfr_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input mcfr_pkg::word_t face_left_i,
  input mcfr_pkg::word_t face_right_i,
  input logic            saturated_i
);

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(face_left_i) && $stable(face_right_i) && $stable(saturated_i))
    else $error("result beat changed while stalled");

  // The pipeline only stops when a finished result is waiting.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled with an empty output");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while the pipeline is frozen");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |=> in_valid_i)
    else $error("input beat withdrawn before it was taken");

endmodule

bind muscl_face_reconstruction_unit mcfr_chk u_mcfr_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .face_left_i  (out_o.face_left),
  .face_right_i (out_o.face_right),
  .saturated_i  (out_o.saturated)
);

`default_nettype wire
